// ===== rtl/core/bpa_pkg.sv =====
// Shared constants and types for the buddy page allocator.
package bpa_pkg;
  localparam int PageW  = 12;
  localparam int OrderW = 4;
  localparam int CountW = 13;
  localparam logic [1:0] OP_ALLOC  = 2'd0;
  localparam logic [1:0] OP_FREE   = 2'd1;
  localparam logic [1:0] OP_DONATE = 2'd2;
  localparam logic [1:0] OP_RSVD   = 2'd3;
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NOMEM  = 2'd1;
  localparam logic [1:0] ST_BAD    = 2'd2;
  localparam logic [1:0] ST_STATE  = 2'd3;
  localparam logic [1:0] KIND_RESERVED = 2'd0;
  localparam logic [1:0] KIND_INSIDE   = 2'd1;
  localparam logic [1:0] KIND_USED     = 2'd2;
  localparam logic [1:0] KIND_FREE     = 2'd3;
  typedef struct packed {
    logic [1:0]        op;
    logic [OrderW-1:0] order;
    logic [PageW-1:0]  page_number;
  } req_t;
  typedef struct packed {
    logic [1:0]        status;
    logic [PageW-1:0]  alloc_page;
    logic [CountW-1:0] free_count;
    logic [CountW-1:0] used_count;
    logic [CountW-1:0] peak_count;
  } rsp_t;
endpackage

// ===== rtl/core/bpa_if.sv =====
// Valid/ready channel interfaces for requests and results.
interface bpa_req_if import bpa_pkg::*; ();
  logic valid;
  logic ready;
  req_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface bpa_rsp_if import bpa_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/core/buddy_page_allocator.sv =====
// Top level of the buddy page allocator.
// One request is handled at a time by a sequencer around a page metadata memory
// (kind, order, links; one registered read port). The order search looks at one
// order at a time, upward from the requested one. Unlinking a block reads its
// entry, then relinks its predecessor (or the list head) and any successor. An
// allocate then pushes the upper half of each split level as a free head (also
// relinking the old head when the list of that order already holds a block),
// marks the block used and presents the result. A free checks the block; each
// merge level reads the buddy and, if it is free at the same order, unlinks it and
// clears the upper half's head mark; a final push lists the merged block. A donate
// first scans every page of the block, marks each page inside, then merges. After
// reset a clearing pass marks all pages reserved, during which no request is taken.
// The result sits in an output register, so the next request is taken while it
// waits; that request's result waits until the register is free.
module buddy_page_allocator import bpa_pkg::*; #(
  parameter int NUM_PAGES = 4096,
  parameter int TOP_ORDER = 10
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [CountW-1:0] cfg_wdata,
  bpa_req_if.sink   req,
  bpa_rsp_if.source rsp
);
  localparam int AW = $clog2(NUM_PAGES);
  localparam int NL = TOP_ORDER + 1;

  // Metadata entry: kind, order, next/prev links with valid flags.
  typedef struct packed {
    logic [1:0]        kind;
    logic [OrderW-1:0] ord;
    logic              nok;
    logic [AW-1:0]     nx;
    logic              pok;
    logic [AW-1:0]     pv;
  } meta_t;

  localparam logic [4:0] S_CLR = 5'd0, S_IDLE = 5'd1, S_SRCH = 5'd2,
    S_UL0 = 5'd3, S_UL1 = 5'd4, S_UL2 = 5'd5, S_UL3 = 5'd6, S_SPL = 5'd7,
    S_PU0 = 5'd8, S_PU1 = 5'd9, S_PU2 = 5'd10, S_FIN = 5'd11, S_FR0 = 5'd12,
    S_FR1 = 5'd13, S_DS0 = 5'd14, S_DS1 = 5'd15, S_DW = 5'd16, S_MG0 = 5'd17,
    S_MG1 = 5'd18, S_MG2 = 5'd19, S_OUT = 5'd20, S_UL4 = 5'd21, S_UL5 = 5'd22,
    S_DS2 = 5'd23;

  meta_t mem [NUM_PAGES];
  meta_t rdata;
  logic  mre, mwe;
  logic [AW-1:0] raddr, waddr;
  meta_t wdata;

  // Metadata memory, one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (mwe) mem[waddr] <= wdata;
    if (mre) rdata <= mem[raddr];
  end

  logic [4:0] state;
  logic [CountW-1:0] total_pages;
  logic [AW-1:0] head [NL];
  logic [NL-1:0] hok;
  logic [CountW-1:0] free_total, used_total, peak_total;
  logic [OrderW-1:0] rord, k;
  logic [AW-1:0] p, b, cnt;
  logic [AW:0] scnt;
  logic [1:0] sts;
  logic [AW-1:0] got;
  meta_t ent;
  logic ul_ret;   // unlink returns to merge when set
  rsp_t out_q;
  logic out_v;

  // Usable page limit, request checks and buddy address, all at full width.
  logic [31:0] lim;
  assign lim = (32'(total_pages) < 32'(NUM_PAGES)) ? 32'(total_pages) : 32'(NUM_PAGES);
  logic [31:0] pg_in;
  assign pg_in = 32'(req.payload.page_number);
  logic [31:0] size_in;
  assign size_in = 32'd1 << req.payload.order;

  logic [31:0] bw;
  assign bw = 32'(p) ^ (32'd1 << k);

  assign req.ready = (state == S_IDLE);
  assign rsp.valid = out_v;
  assign rsp.payload = out_q;

  // Sequencer.
  always_ff @(posedge clk) begin
    mre <= 1'b0;
    mwe <= 1'b0;
    if (rst) begin
      state <= S_CLR;
      total_pages <= CountW'(4096);
      hok <= '0;
      free_total <= '0; used_total <= '0; peak_total <= '0;
      cnt <= '0;
      out_v <= 1'b0;
    end else begin
      if (cfg_we) total_pages <= cfg_wdata;
      if (out_v && rsp.ready) out_v <= 1'b0;
      case (state)
        S_CLR: begin
          mwe <= 1'b1; waddr <= cnt; wdata <= '0;
          cnt <= cnt + AW'(1);
          if (cnt == AW'(NUM_PAGES-1)) state <= S_IDLE;
        end
        S_IDLE: if (req.valid && req.ready) begin
          rord <= req.payload.order;
          k <= req.payload.order; p <= AW'(req.payload.page_number);
          sts <= ST_OK; got <= '0;
          if (req.payload.op == OP_RSVD || req.payload.order > OrderW'(TOP_ORDER)) begin
            sts <= ST_BAD; state <= S_OUT;
          end else if (req.payload.op == OP_ALLOC) begin
            state <= S_SRCH;
          end else if (pg_in >= lim || (pg_in & (size_in - 32'd1)) != 32'd0) begin
            sts <= ST_BAD; state <= S_OUT;
          end else if (req.payload.op == OP_FREE) begin
            mre <= 1'b1; raddr <= AW'(req.payload.page_number); state <= S_FR0;
          end else if (pg_in + size_in > lim) begin
            sts <= ST_BAD; state <= S_OUT;
          end else begin
            scnt <= '0; state <= S_DS0;
          end
        end
        // Allocate: find the smallest nonempty order.
        S_SRCH: begin
          if (hok[k]) begin
            p <= head[k]; b <= head[k];
            mre <= 1'b1; raddr <= head[k];
            ul_ret <= 1'b0; state <= S_UL0;
          end else if (k == OrderW'(TOP_ORDER)) begin
            sts <= ST_NOMEM; state <= S_OUT;
          end else k <= k + OrderW'(1);
        end
        // Unlink block b from list k; its entry is used in S_UL1.
        S_UL0: state <= S_UL1;
        S_UL1: begin
          ent <= rdata;
          if (!rdata.pok) begin
            head[k] <= rdata.nx; hok[k] <= rdata.nok; state <= S_UL3;
          end else begin
            mre <= 1'b1; raddr <= rdata.pv; state <= S_UL2;
          end
        end
        S_UL2: state <= S_UL4;
        S_UL4: begin
          mwe <= 1'b1; waddr <= ent.pv;
          wdata <= '{kind: rdata.kind, ord: rdata.ord, nok: ent.nok, nx: ent.nx,
                     pok: rdata.pok, pv: rdata.pv};
          state <= S_UL3;
        end
        S_UL3: begin
          if (ent.nok) begin
            mre <= 1'b1; raddr <= ent.nx; state <= S_DW;
          end else begin
            if (ul_ret) state <= S_MG2;
            else begin free_total <= free_total - (CountW'(1) << k); state <= S_SPL; end
          end
        end
        S_DW: state <= S_UL5;
        S_UL5: begin
          mwe <= 1'b1; waddr <= ent.nx;
          wdata <= '{kind: rdata.kind, ord: rdata.ord, nok: rdata.nok, nx: rdata.nx,
                     pok: ent.pok, pv: ent.pv};
          if (ul_ret) state <= S_MG2;
          else begin free_total <= free_total - (CountW'(1) << k); state <= S_SPL; end
        end
        // Split: push the upper half of each level.
        S_SPL: begin
          if (k == rord) state <= S_FIN;
          else begin
            k <= k - OrderW'(1);
            b <= p + (AW'(1) << (k - OrderW'(1)));
            free_total <= free_total + (CountW'(1) << (k - OrderW'(1)));
            ul_ret <= 1'b0;
            state <= S_PU0;
          end
        end
        // Push block b as a free head on list k.
        S_PU0: begin
          mwe <= 1'b1; waddr <= b;
          wdata <= '{kind: KIND_FREE, ord: k, nok: hok[k], nx: head[k], pok: 1'b0,
                     pv: '0};
          if (hok[k]) begin mre <= 1'b1; raddr <= head[k]; state <= S_PU1; end
          else begin head[k] <= b; hok[k] <= 1'b1; state <= ul_ret ? S_OUT : S_SPL; end
        end
        S_PU1: state <= S_PU2;
        S_PU2: begin
          mwe <= 1'b1; waddr <= head[k];
          wdata <= '{kind: rdata.kind, ord: rdata.ord, nok: rdata.nok, nx: rdata.nx,
                     pok: 1'b1, pv: b};
          head[k] <= b; hok[k] <= 1'b1;
          state <= ul_ret ? S_OUT : S_SPL;
        end
        S_FIN: begin
          mwe <= 1'b1; waddr <= p;
          wdata <= '{kind: KIND_USED, ord: rord, nok: 1'b0, nx: '0, pok: 1'b0, pv: '0};
          got <= p;
          used_total <= used_total + (CountW'(1) << rord);
          if (used_total + (CountW'(1) << rord) > peak_total)
            peak_total <= used_total + (CountW'(1) << rord);
          state <= S_OUT;
        end
        // Free: check the head entry.
        S_FR0: state <= S_FR1;
        S_FR1: begin
          if (rdata.kind != KIND_USED || rdata.ord != rord) begin
            sts <= ST_STATE; state <= S_OUT;
          end else begin
            free_total <= free_total + (CountW'(1) << rord);
            used_total <= used_total - (CountW'(1) << rord);
            state <= S_MG0;
          end
        end
        // Donate: scan every page for reserved, then mark inside.
        S_DS0: begin
          mre <= 1'b1; raddr <= p + scnt[AW-1:0]; state <= S_DS1;
        end
        S_DS1: if (!mre) begin
          if (rdata.kind != KIND_RESERVED) begin sts <= ST_STATE; state <= S_OUT; end
          else if (scnt + 1'b1 == ((AW+1)'(1) << rord)) begin
            scnt <= '0; state <= S_DS2;
          end else begin scnt <= scnt + 1'b1; state <= S_DS0; end
        end
        S_DS2: begin
          mwe <= 1'b1; waddr <= p + scnt[AW-1:0];
          wdata <= '{kind: KIND_INSIDE, ord: '0, nok: 1'b0, nx: '0, pok: 1'b0, pv: '0};
          if (scnt + 1'b1 == ((AW+1)'(1) << rord)) begin
            free_total <= free_total + (CountW'(1) << rord); state <= S_MG0;
          end else scnt <= scnt + 1'b1;
        end
        // Merge: read the buddy of p at order k.
        S_MG0: begin
          if (k < OrderW'(TOP_ORDER) && bw < lim) begin
            b <= bw[AW-1:0]; mre <= 1'b1; raddr <= bw[AW-1:0]; state <= S_MG1;
          end else begin
            ul_ret <= 1'b1; b <= p; state <= S_PU0;
          end
        end
        S_MG1: if (!mre) begin
          if (rdata.kind == KIND_FREE && rdata.ord == k) begin
            ent <= rdata; ul_ret <= 1'b1;
            state <= S_UL1; mre <= 1'b1; raddr <= b;
          end else begin
            ul_ret <= 1'b1; b <= p; state <= S_PU0;
          end
        end
        S_MG2: begin
          // Upper half loses its head mark.
          mwe <= 1'b1;
          waddr <= (b < p) ? p : b;
          wdata <= '{kind: KIND_INSIDE, ord: '0, nok: 1'b0, nx: '0, pok: 1'b0, pv: '0};
          if (b < p) p <= b;
          k <= k + OrderW'(1);
          state <= S_MG0;
        end
        // Present the result once the output register is free.
        S_OUT: if (!out_v || rsp.ready) begin
          out_q <= '{status: sts, alloc_page: PageW'(got), free_count: free_total,
                     used_count: used_total, peak_count: peak_total};
          out_v <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
